[hw/rtl/npc_pkg.sv]
`timescale 1ns / 1ps

package npc_pkg;

    localparam int TARGET_COLORS = 16;
    localparam int SOURCE_COLORS = 256;

    localparam int TGT_W  = $clog2(TARGET_COLORS);
    localparam int SRC_W  = $clog2(SOURCE_COLORS);
    localparam int SQ_W   = 16;
    localparam int DIST_W = SQ_W + 2;

    typedef enum logic [1:0] {
        OP_LOAD_SRC = 2'd0,
        OP_LOAD_TGT = 2'd1,
        OP_PIXEL    = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SEARCH,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // squared component differences for one target entry, tagged with its index
    typedef struct packed {
        logic             valid;
        logic [TGT_W-1:0] tag;
        logic [SQ_W-1:0]  sq_red;
        logic [SQ_W-1:0]  sq_green;
        logic [SQ_W-1:0]  sq_blue;
    } sq_t;

    function automatic rgb_t default_target(int unsigned i);
        rgb_t c;
        c.red   = ((i & 8) != 0) ? 8'd192 : 8'd64;
        c.green = 8'(32 + 64 * (i & 3));
        c.blue  = ((i & 4) != 0) ? 8'd192 : 8'd64;
        return c;
    endfunction

endpackage

[hw/rtl/npc_sqdist.sv]
`timescale 1ns / 1ps

module npc_sqdist
    import npc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             issue,
    input  logic [TGT_W-1:0] tag,
    input  rgb_t             color_a,
    input  rgb_t             color_b,
    output sq_t              result
);

    sq_t result_reg;

    function automatic logic [SQ_W-1:0] sq_diff(logic [7:0] a, logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_reg.valid <= 1'b0;
        end else begin
            result_reg.valid <= issue;
        end
        result_reg.tag      <= tag;
        result_reg.sq_red   <= sq_diff(color_a.red,   color_b.red);
        result_reg.sq_green <= sq_diff(color_a.green, color_b.green);
        result_reg.sq_blue  <= sq_diff(color_a.blue,  color_b.blue);
    end

    assign result = result_reg;

endmodule

[hw/rtl/nearest_palette_color_packer_unit.sv]
`timescale 1ns / 1ps

// Nearest palette color packer. Load transactions (op 0 source entry, op 1
// target entry) are taken one per cycle while no pixel is in progress. A
// pixel transaction looks up its source color in a single-port source
// palette RAM, then one shared squared-distance unit walks the target palette
// one entry per cycle, with its squares registered and summed/compared in
// the cycle after. A pixel passes through the reduce state (subtracting
// SOURCE_COLORS as needed to bring its index into range, never at 256, then
// reading the source), then the search, drain and finish states; the next
// transaction is accepted back in idle. Every second pixel of a row emits a
// byte, earlier pixel in the high nibble; a pixel that must emit while the
// previous byte is still waiting holds until the output register frees.
// row_start drops any pending nibble. Source entries must be written
// before they are read; the target palette resets to the default class centers.
module nearest_palette_color_packer_unit
    import npc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_index,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic       s_row_start,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_packed_byte
);

    state_t state_reg, state_next;

    rgb_t src_mem [SOURCE_COLORS];
    rgb_t src_rd_reg;
    rgb_t tgt_reg [TARGET_COLORS];

    logic [7:0]        idx_reg, idx_next;
    logic [TGT_W-1:0]  cnt_reg, cnt_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [TGT_W-1:0]  pick_reg, pick_next;
    logic [3:0]        pending_reg, pending_next;
    logic              odd_reg, odd_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_byte_reg, m_byte_next;

    logic              accept;
    logic              need_sub;
    logic              last_tgt;
    logic              out_free;
    logic              src_wr_en;
    logic              tgt_wr_en;
    logic              rd_en;
    logic              issue;
    logic              emit;
    logic [DIST_W-1:0] cand_dist;
    logic [3:0]        nib;
    sq_t               sq;

    assign accept   = s_valid && s_ready;
    assign need_sub = {1'b0, idx_reg} >= 9'(SOURCE_COLORS);
    assign last_tgt = (cnt_reg == TGT_W'(TARGET_COLORS - 1));
    assign out_free = !m_valid_reg || m_ready;
    assign nib      = 4'(pick_reg);

    assign src_wr_en = accept && (op_t'(s_op) == OP_LOAD_SRC)
                       && ({1'b0, s_index} < 9'(SOURCE_COLORS));
    assign tgt_wr_en = accept && (op_t'(s_op) == OP_LOAD_TGT)
                       && ({1'b0, s_index} < 9'(TARGET_COLORS));

    npc_sqdist u_sqdist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .tag     (cnt_reg),
        .color_a (src_rd_reg),
        .color_b (tgt_reg[cnt_reg]),
        .result  (sq)
    );

    assign cand_dist = {2'b00, sq.sq_red} + {2'b00, sq.sq_green} + {2'b00, sq.sq_blue};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (op_t'(s_op) == OP_PIXEL)) begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (!need_sub) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (last_tgt) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!odd_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        issue   = 1'b0;
        emit    = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_REDUCE: rd_en   = !need_sub;
            ST_SEARCH: issue   = 1'b1;
            ST_FINISH: emit    = odd_reg && out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        best_next    = best_reg;
        pick_next    = pick_reg;
        pending_next = pending_reg;
        odd_next     = odd_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept && (op_t'(s_op) == OP_PIXEL)) begin
            idx_next = s_index;
            if (s_row_start) begin
                odd_next = 1'b0;
            end
        end

        if (state_reg == ST_REDUCE) begin
            cnt_next  = '0;
            best_next = '1;
            if (need_sub) begin
                idx_next = idx_reg - 8'(SOURCE_COLORS);
            end
        end

        if (issue) begin
            cnt_next = cnt_reg + 1'b1;
        end

        // strict less-than keeps the lower index on a tie
        if (sq.valid && (cand_dist < best_reg)) begin
            best_next = cand_dist;
            pick_next = sq.tag;
        end

        if (state_reg == ST_FINISH) begin
            if (!odd_reg) begin
                pending_next = nib;
                odd_next     = 1'b1;
            end else if (emit) begin
                m_valid_next = 1'b1;
                m_byte_next  = {pending_reg, nib};
                odd_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            odd_reg     <= 1'b0;
            pending_reg <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            odd_reg     <= odd_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
        idx_reg    <= idx_next;
        best_reg   <= best_next;
        pick_reg   <= pick_next;
        m_byte_reg <= m_byte_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TARGET_COLORS; i++) begin
                tgt_reg[i] <= default_target(i);
            end
        end else if (tgt_wr_en) begin
            tgt_reg[s_index[TGT_W-1:0]] <= '{red: s_red, green: s_green, blue: s_blue};
        end
    end

    always_ff @(posedge aclk) begin
        if (src_wr_en) begin
            src_mem[s_index[SRC_W-1:0]] <= '{red: s_red, green: s_green, blue: s_blue};
        end
        if (rd_en) begin
            src_rd_reg <= src_mem[idx_reg[SRC_W-1:0]];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_packed_byte = m_byte_reg;

endmodule
